### sv/sgu_pkg.sv
`default_nettype none

package sgu_pkg;

  // Fixed field widths of the command and result channels
  localparam int DataW = 64;
  localparam int IdxW  = 6;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  // Row memory read address source
  typedef enum logic [1:0] {
    RA_INDEX,
    RA_GROUND,
    RA_ABOVE
  } rd_addr_e;

  // Row memory write source
  typedef enum logic [1:0] {
    WS_ZERO,
    WS_BELOW,
    WS_TOP
  } wr_src_e;

  typedef struct packed {
    logic     cnt_up;
    logic     cnt_down;
    logic     cnt_ground;
    logic     rd_en;
    rd_addr_e rd_addr;
    logic     wr_en;
    wr_src_e  wr_src;
    logic     load_below;
    logic     step_row;
    logic     capture;
    logic     out_load;
  } ctrl_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### sv/snowfall_grid_update.sv
// Snow grid automaton: GRID_HEIGHT rows of GRID_WIDTH one-bit cells kept
// in a single-read, single-write row memory.
// Command channel (in_valid_i/in_ready_o): cmd_i = tick applies one update
// sweep and then ORs spawn_mask_i into the top row; cmd_i = read returns
// row row_index_i (0 is the top row, rows past the bottom read as zero).
// Result channel (out_valid_o/out_ready_i): exactly one transaction per
// command. A read answers with row_data_o and is_read_answer_o = 1; a tick
// is acknowledged with row_data_o = 0 and is_read_answer_o = 0.
// One command at a time. A read moves the row from memory into a read
// register, then into the output register once it is free. A tick runs a
// load state, one sweep state per row from the second lowest to the top
// (a memory write in each, a read in all but the last; the row below is
// held in a register), then top-row spawn and result states. in_ready_o
// rises in the same cycle that the result appears. Reset clears the memory
// one row a cycle, with in_ready_o low; commands are taken after that.
// Receiver stall: a result waits in the output register; the block finishes
// its command and holds until that register is free, and takes no new
// command meanwhile.
`default_nettype none

module snowfall_grid_update import sgu_pkg::*; #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             cmd_i,
  input  wire logic [DataW-1:0] spawn_mask_i,
  input  wire logic [IdxW-1:0]  row_index_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [DataW-1:0]      row_data_o,
  output logic                  is_read_answer_o
);

  ctrl_t   ctrl;
  status_t status;

  sgu_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  sgu_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .cmd_i            (cmd_i),
    .spawn_mask_i     (spawn_mask_i),
    .row_index_i      (row_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .row_data_o       (row_data_o),
    .is_read_answer_o (is_read_answer_o)
  );

endmodule

`default_nettype wire

### sv/sgu_datapath.sv
`default_nettype none

module sgu_datapath import sgu_pkg::*; #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_t             ctrl_i,
  output status_t                status_o,
  input  wire logic              cmd_i,
  input  wire logic [DataW-1:0]  spawn_mask_i,
  input  wire logic [IdxW-1:0]   row_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [DataW-1:0]       row_data_o,
  output logic                   is_read_answer_o
);

  localparam int RowW = $clog2(GRID_HEIGHT);
  localparam int CmpW = (RowW >= IdxW) ? RowW + 1 : IdxW + 1;
  localparam logic [RowW-1:0] GroundRow = RowW'(GRID_HEIGHT - 1);
  localparam int W = GRID_WIDTH;

  logic [W-1:0] mem_q [GRID_HEIGHT];
  logic [W-1:0] rd_q;
  logic [W-1:0] below_q;
  logic [W-1:0] spawn_q;
  logic [W-1:0] wr_data;
  logic [RowW-1:0] rd_addr;
  logic [RowW-1:0] wr_addr;
  logic [RowW-1:0] cnt_q, cnt_d;
  logic [CmpW-1:0] idx_ext;
  logic is_read_q;
  logic oob_q;
  logic out_valid_q;
  logic [DataW-1:0] row_data_q;
  logic is_read_ans_q;

  // Row update terms
  logic [W-1:0] cur, b1, gen, prop, fcar, bb, occ, fell, mv_r, mv_l;
  logic [W-1:0] new_cur, new_below;
  logic col0_full;

  assign idx_ext = CmpW'(row_index_i);

  // One row against the row below. Right moves form a carry chain
  // (generate where the own cell below is full, propagate where a flake
  // from the left fills it), so it is computed with one add.
  always_comb begin
    cur = rd_q;
    b1  = below_q;
    // column 0 may wrap left into the last column before the rest runs
    b1[W-1] = below_q[W-1] | (cur[0] & below_q[0] & below_q[1]);
    gen  = '0;
    prop = '0;
    for (int c = 0; c < W - 1; c++) begin
      gen[c]  = cur[c] & b1[c] & ~b1[c+1];
      prop[c] = cur[c] & ~b1[c] & ~b1[c+1];
    end
    fcar = ((gen | prop) + gen) ^ (gen | prop) ^ gen;
    bb   = b1 | fcar;
    fell = cur & ~bb;
    occ  = bb | cur;
    mv_r = '0;
    mv_l = '0;
    for (int c = 0; c < W - 1; c++) begin
      mv_r[c] = fcar[c+1];
    end
    mv_l[0] = cur[0] & below_q[0] & below_q[1] & ~below_q[W-1];
    for (int c = 1; c < W - 1; c++) begin
      mv_l[c] = cur[c] & bb[c] & b1[c+1] & ~occ[c-1];
    end
    col0_full = occ[0] | mv_l[1];
    mv_r[W-1] = cur[W-1] & bb[W-1] & ~col0_full;
    mv_l[W-1] = cur[W-1] & bb[W-1] & col0_full & ~occ[W-2];
    new_cur   = cur & ~(fell | mv_r | mv_l);
    new_below = b1 | fell | fcar | (mv_l >> 1) | W'(mv_r[W-1]);
  end

  always_comb begin
    case (ctrl_i.rd_addr)
      RA_INDEX:  rd_addr = idx_ext[RowW-1:0];
      RA_GROUND: rd_addr = GroundRow;
      RA_ABOVE:  rd_addr = cnt_q - RowW'(1);
      default:   rd_addr = cnt_q;
    endcase
    case (ctrl_i.wr_src)
      WS_ZERO: begin
        wr_addr = cnt_q;
        wr_data = '0;
      end
      WS_BELOW: begin
        wr_addr = cnt_q + RowW'(1);
        wr_data = new_below;
      end
      WS_TOP: begin
        wr_addr = '0;
        wr_data = below_q | spawn_q;
      end
      default: begin
        wr_addr = cnt_q;
        wr_data = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.cnt_ground) begin
      cnt_d = GroundRow;
    end else if (ctrl_i.cnt_up) begin
      cnt_d = cnt_q + RowW'(1);
    end else if (ctrl_i.cnt_down) begin
      cnt_d = cnt_q - RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      spawn_q   <= spawn_mask_i[W-1:0];
      is_read_q <= (cmd_i == CMD_READ);
      oob_q     <= (idx_ext >= CmpW'(GRID_HEIGHT));
    end
    if (ctrl_i.load_below) begin
      below_q <= rd_q;
    end else if (ctrl_i.step_row) begin
      below_q <= new_cur;
    end
    if (ctrl_i.out_load) begin
      row_data_q    <= (is_read_q && !oob_q) ? DataW'(rd_q) : '0;
      is_read_ans_q <= is_read_q;
    end
  end

  assign status_o = '{
    cnt_last: (cnt_q == GroundRow),
    cnt_zero: (cnt_q == '0),
    out_free: (!out_valid_q || out_ready_i)
  };

  assign out_valid_o      = out_valid_q;
  assign row_data_o       = row_data_q;
  assign is_read_answer_o = is_read_ans_q;

endmodule

`default_nettype wire

### sv/sgu_controller.sv
`default_nettype none

module sgu_controller import sgu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    cmd_i,
  input  wire status_t status_i,
  output logic         in_ready_o,
  output ctrl_t        ctrl_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOAD,
    S_SWEEP,
    S_TOP,
    S_ACK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_src = WS_ZERO;
        if (status_i.cnt_last) begin
          state_d = S_IDLE;
        end else begin
          ctrl_o.cnt_up = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          ctrl_o.rd_en   = 1'b1;
          if (cmd_i == CMD_READ) begin
            ctrl_o.rd_addr = RA_INDEX;
            state_d        = S_READ;
          end else begin
            ctrl_o.rd_addr    = RA_GROUND;
            ctrl_o.cnt_ground = 1'b1;
            state_d           = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        ctrl_o.load_below = 1'b1;
        ctrl_o.rd_en      = 1'b1;
        ctrl_o.rd_addr    = RA_ABOVE;
        ctrl_o.cnt_down   = 1'b1;
        state_d           = S_SWEEP;
      end
      S_SWEEP: begin
        ctrl_o.wr_en    = 1'b1;
        ctrl_o.wr_src   = WS_BELOW;
        ctrl_o.step_row = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = S_TOP;
        end else begin
          ctrl_o.rd_en    = 1'b1;
          ctrl_o.rd_addr  = RA_ABOVE;
          ctrl_o.cnt_down = 1'b1;
        end
      end
      S_TOP: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wr_src = WS_TOP;
        state_d       = S_ACK;
      end
      S_READ, S_ACK: begin
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/sgu_checker.sv
`default_nettype none

module sgu_checker import sgu_pkg::*; #(
  parameter int GRID_WIDTH = 64
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [DataW-1:0] row_data_o,
  input wire logic             is_read_answer_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_data_o)
      && $stable(is_read_answer_o))
    else $error("result changed while stalled");

  a_tick_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_read_answer_o |-> row_data_o == '0)
    else $error("tick acknowledge carries row data");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command taken while busy");

  a_row_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (row_data_o >> GRID_WIDTH) == '0)
    else $error("row data beyond grid width");

endmodule

bind snowfall_grid_update sgu_checker #(.GRID_WIDTH(GRID_WIDTH)) u_sgu_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

// Snow grid testbench.
// A short directed table runs first: empty grid after reset, a full spawn row
// falling one row a tick, stacking in one column so flakes slide diagonally,
// and spawns at both ends of the row so the column wrap is exercised.
// Random commands follow. Spawns are sparse in the first half, dense in the
// second, so the grid fills up, the ground row holds snow, and spawns finally
// land on snow. Every accepted command is run through a local copy of the
// grid, and each result transaction is matched in order against the
// predicted answer queue.
module tb;
  import sgu_pkg::*;

  localparam int GridW = 64;
  localparam int GridH = 64;
  localparam logic [DataW-1:0] RowMask = {DataW{1'b1}} >> (DataW - GridW);
  localparam logic [DataW-1:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int RandItems   = 480;
  localparam int QuietItems  = 60;    // tail of the run with no gaps at all
  localparam int HoldAtItem  = 120;   // where the sink holds off for a long time
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 3000;  // cycles with no transaction on either side
  localparam int DrainCycles = GridH + 8;

  typedef struct packed {
    logic [DataW-1:0] row;
    logic             is_read;
  } answer_t;

  // One directed command; want is used only where typed is set.
  typedef struct {
    cmd_e             op;
    logic [DataW-1:0] mask;
    logic [IdxW-1:0]  row;
    bit               typed;
    logic [DataW-1:0] want;
  } dir_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  cmd_e             op_q = CMD_TICK;
  logic [DataW-1:0] mask_q = '0;
  logic [IdxW-1:0]  row_q = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DataW-1:0] row_data;
  logic             is_read_answer;

  // local copy of the grid, row 0 on top
  logic [DataW-1:0] snow_rows [GridH];
  answer_t          snow_answers [$];

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  bit  no_gaps = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  // Directed table. Ticks always acknowledge with zero data; reads are typed
  // only where the grid is obvious.
  dir_cmd_t dir_cmds [22] = '{
    '{CMD_READ, 64'h0, 6'd0, 1'b1, 64'h0},          // empty after reset
    '{CMD_READ, 64'h0, 6'd63, 1'b1, 64'h0},
    '{CMD_READ, 64'h0, 6'd31, 1'b1, 64'h0},
    '{CMD_TICK, AllOnes, 6'd0, 1'b1, 64'h0},        // full spawn row
    '{CMD_READ, 64'h0, 6'd0, 1'b1, AllOnes},
    '{CMD_TICK, 64'h0, 6'd0, 1'b1, 64'h0},
    '{CMD_READ, 64'h0, 6'd0, 1'b1, 64'h0},          // row fell one down
    '{CMD_READ, 64'h0, 6'd1, 1'b1, AllOnes},
    '{CMD_TICK, 64'h8000_0000_0000_0001, 6'd0, 1'b1, 64'h0}, // both ends
    '{CMD_READ, 64'h0, 6'd0, 1'b0, 64'h0},
    '{CMD_TICK, 64'h1, 6'd0, 1'b1, 64'h0},          // stack on column 0
    '{CMD_TICK, 64'h1, 6'd0, 1'b1, 64'h0},
    '{CMD_TICK, 64'h1, 6'd0, 1'b1, 64'h0},
    '{CMD_TICK, 64'h8000_0000_0000_0000, 6'd0, 1'b1, 64'h0},
    '{CMD_READ, 64'h0, 6'd2, 1'b0, 64'h0},
    '{CMD_READ, 64'h0, 6'd3, 1'b0, 64'h0},
    '{CMD_TICK, 64'hAAAA_AAAA_AAAA_AAAA, 6'd0, 1'b1, 64'h0},
    '{CMD_TICK, 64'h5555_5555_5555_5555, 6'd0, 1'b1, 64'h0},
    '{CMD_READ, 64'h0, 6'd0, 1'b0, 64'h0},
    '{CMD_READ, 64'h0, 6'd1, 1'b0, 64'h0},
    '{CMD_READ, 64'h0, 6'd62, 1'b0, 64'h0},
    '{CMD_READ, 64'h0, 6'd63, 1'b0, 64'h0}          // ground row
  };

  snowfall_grid_update #(
    .GRID_WIDTH (GridW),
    .GRID_HEIGHT(GridH)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (op_q),
    .spawn_mask_i    (mask_q),
    .row_index_i     (row_q),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .row_data_o      (row_data),
    .is_read_answer_o(is_read_answer)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Grid update for one accepted command. The sweep goes bottom-up from the
  // second lowest row; each flake tries straight down, then down-right, then
  // down-left, with the columns wrapping. The spawn mask lands after the sweep.
  function automatic answer_t predict_answer(cmd_e op, logic [DataW-1:0] mask,
                                             logic [IdxW-1:0] row);
    answer_t          ans;
    logic [DataW-1:0] cur;
    logic [DataW-1:0] below;
    int               right;
    int               left;

    ans = '{row: '0, is_read: 1'b0};
    if (op == CMD_TICK) begin
      for (int r = GridH - 2; r >= 0; r--) begin
        cur   = snow_rows[r];
        below = snow_rows[r + 1];
        for (int c = 0; c < GridW; c++) begin
          if (cur[c]) begin
            right = (c == GridW - 1) ? 0 : c + 1;
            left  = (c == 0) ? GridW - 1 : c - 1;
            if (!below[c]) begin
              below[c] = 1'b1;
              cur[c]   = 1'b0;
            end else if (!below[right]) begin
              below[right] = 1'b1;
              cur[c]       = 1'b0;
            end else if (!below[left]) begin
              below[left] = 1'b1;
              cur[c]      = 1'b0;
            end
          end
        end
        snow_rows[r]     = cur & RowMask;
        snow_rows[r + 1] = below & RowMask;
      end
      snow_rows[0] = (snow_rows[0] | mask) & RowMask;
    end else begin
      ans.is_read = 1'b1;
      if (int'(row) < GridH) begin
        ans.row = snow_rows[row];
      end
    end
    return ans;
  endfunction

  // Offer one command transaction; called at a falling edge, returns at one.
  // An optional gap with in_valid low comes first.
  task automatic offer_cmd(cmd_e op, logic [DataW-1:0] mask, logic [IdxW-1:0] row,
                           bit typed, logic [DataW-1:0] want);
    answer_t ans;

    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    op_q     <= op;
    mask_q   <= mask;
    row_q    <= row;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ans = predict_answer(op, mask, row);
    if (typed) begin
      ans = '{row: want, is_read: op == CMD_READ};
    end
    snow_answers.push_back(ans);
    @(negedge clk);
  endtask

  // Result sink: random stall bursts, plus one long hold-off while commands
  // keep coming, so the block backs up and drops in_ready.
  initial begin : result_sink
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Match each result transaction against the oldest predicted answer.
  always @(posedge clk) begin : answer_check
    answer_t want;

    if (rst_n && out_valid && out_ready) begin
      if (snow_answers.size() == 0) begin
        $error("result with nothing pending: row_data %h, is_read_answer %b",
               row_data, is_read_answer);
        mismatch_count++;
      end else begin
        want = snow_answers.pop_front();
        if (row_data !== want.row) begin
          $error("row_data: expected %h, got %h", want.row, row_data);
          mismatch_count++;
        end
        if (is_read_answer !== want.is_read) begin
          $error("is_read_answer: expected %b, got %b", want.is_read, is_read_answer);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without a transaction on either channel means a hang.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cmd_e             op;
    logic [DataW-1:0] mask;
    logic [IdxW-1:0]  row;
    int               pick;

    for (int r = 0; r < GridH; r++) begin
      snow_rows[r] = '0;
    end
    // reset held low first; the block then clears its memory with in_ready low
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_cmds[i]) begin
      offer_cmd(dir_cmds[i].op, dir_cmds[i].mask, dir_cmds[i].row,
                dir_cmds[i].typed, dir_cmds[i].want);
    end

    // Random part: sparse spawns first, dense later so the grid saturates.
    for (int n = 0; n < RandItems; n++) begin
      no_gaps = (n >= RandItems - QuietItems);
      if (n == HoldAtItem) begin
        hold_req = 1'b1;
      end
      op   = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_READ;
      pick = (n < RandItems / 2) ? $urandom_range(0, 3) : $urandom_range(2, 6);
      case (pick)
        0: begin
          mask = '0;
        end
        1: begin
          mask = RowMask & (64'd1 << $urandom_range(0, GridW - 1));
        end
        2: begin
          mask = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        end
        3: begin
          mask = {$urandom, $urandom} & {$urandom, $urandom};
        end
        4: begin
          mask = {$urandom, $urandom};
        end
        5: begin
          mask = {$urandom, $urandom} | {$urandom, $urandom};
        end
        default: begin
          mask = AllOnes;
        end
      endcase
      row = IdxW'($urandom_range(0, 63));
      offer_cmd(op, mask, row, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain, then a quiet stretch to catch stray results
    while (snow_answers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
